### sv/rcsfd_pkg.sv
// ---------------------------------------------------------------------------
// rcsfd_pkg
// shared types and constants of the rc serial frame decoder
// ---------------------------------------------------------------------------
package rcsfd_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'h0F;
    localparam logic [7:0] END_BYTE    = 8'h00;

    localparam int STORE_LEN   = 23;
    localparam int DATA_BYTES  = 22;
    localparam int FLAG_POS    = 22;
    localparam int FRAME_TAIL  = 24;
    localparam int CH_W        = 11;
    localparam int DATA_W      = DATA_BYTES * 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] LAST_CH_ALL  = 4'd15;
    localparam logic [3:0] LAST_CH_HALF = 4'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FAILSAFE = 2'd1;
    localparam logic [1:0] STATUS_LOST     = 2'd2;

    localparam int FLAG_DIGITAL_ONE = 0;
    localparam int FLAG_DIGITAL_TWO = 1;
    localparam int FLAG_FAILSAFE    = 2;
    localparam int FLAG_LOST        = 3;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_END   = 1'b1;

    localparam logic ACTION_BYTE = 1'b0;

    typedef struct packed {
        logic       op;
        logic [4:0] idx;
        logic [7:0] data;
    } qent_t;

    typedef struct packed {
        logic [4:0]      pad;
        logic [1:0]      signal_status;
        logic            digital_two;
        logic            digital_one;
        logic [CH_W-1:0] channel_value;
        logic [3:0]      channel_index;
    } result_t;

endpackage

### sv/rcsfd_front.sv
// ---------------------------------------------------------------------------
// rcsfd_front
// header hunt and byte count, turns accepted bytes into queue commands
// ---------------------------------------------------------------------------
module rcsfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // rx_byte
    input  logic              s_axis_tuser,   // action
    input  logic              q_full,
    output logic              q_push,
    output rcsfd_pkg::qent_t  q_entry
);

    logic       collecting_reg;
    logic       collecting_next;
    logic [4:0] count_reg;
    logic [4:0] count_next;
    logic [4:0] count_inc;
    logic       accept;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign count_inc     = count_reg + 5'd1;

    always_comb
    begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        q_push          = 1'b0;
        q_entry.op      = rcsfd_pkg::OP_STORE;
        q_entry.idx     = count_reg;
        q_entry.data    = s_axis_tdata;
        if (accept)
        begin
            if (s_axis_tuser != rcsfd_pkg::ACTION_BYTE)
            begin
                collecting_next = 1'b0;
                count_next      = 5'd0;
            end
            else if (!collecting_reg)
            begin
                if (s_axis_tdata == rcsfd_pkg::HDR_BYTE)
                begin
                    collecting_next = 1'b1;
                    count_next      = 5'd0;
                end
            end
            else if (count_inc <= 5'(rcsfd_pkg::STORE_LEN))
            begin
                count_next = count_inc;
                q_push     = 1'b1;
            end
            else
            begin
                collecting_next = 1'b0;
                count_next      = 5'd0;
                q_entry.op      = rcsfd_pkg::OP_END;
                q_push          = (s_axis_tdata == rcsfd_pkg::END_BYTE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            count_reg      <= 5'd0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
        end
    end

endmodule

### sv/rcsfd_fifo.sv
// ---------------------------------------------------------------------------
// rcsfd_fifo
// short command queue between the front and the back
// ---------------------------------------------------------------------------
module rcsfd_fifo #(
    parameter int DEPTH = rcsfd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rcsfd_pkg::qent_t  push_entry,
    input  logic              pop,
    output rcsfd_pkg::qent_t  pop_entry,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcsfd_pkg::qent_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                              wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 :
                              rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### sv/rcsfd_back.sv
// ---------------------------------------------------------------------------
// rcsfd_back
// frame store, channel unpack shifter and registered result stage
// ---------------------------------------------------------------------------
module rcsfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              full_decode,
    input  rcsfd_pkg::qent_t  q_entry,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,
    output logic              m_axis_tlast
);

    logic [rcsfd_pkg::DATA_W-1:0] data_reg;
    logic [rcsfd_pkg::DATA_W-1:0] data_next;
    logic [7:0]                   flags_reg;
    logic [7:0]                   flags_next;
    logic                         emitting_reg;
    logic                         emitting_next;
    logic [3:0]                   ch_reg;
    logic [3:0]                   ch_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    rcsfd_pkg::result_t           out_data_reg;
    rcsfd_pkg::result_t           out_data_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         out_free;
    logic                         step;
    logic [3:0]                   last_ch;
    logic [1:0]                   status;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign step     = emitting_reg && out_free;
    assign q_pop    = !emitting_reg && !q_empty;
    assign last_ch  = full_decode ? rcsfd_pkg::LAST_CH_ALL : rcsfd_pkg::LAST_CH_HALF;
    assign status   = flags_reg[rcsfd_pkg::FLAG_LOST]     ? rcsfd_pkg::STATUS_LOST :
                      flags_reg[rcsfd_pkg::FLAG_FAILSAFE] ? rcsfd_pkg::STATUS_FAILSAFE :
                                                            rcsfd_pkg::STATUS_OK;

    always_comb
    begin
        data_next      = data_reg;
        flags_next     = flags_reg;
        emitting_next  = emitting_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (q_pop)
        begin
            if (q_entry.op == rcsfd_pkg::OP_END)
            begin
                emitting_next = 1'b1;
                ch_next       = 4'd0;
            end
            else if (q_entry.idx == 5'(rcsfd_pkg::FLAG_POS))
            begin
                flags_next = q_entry.data;
            end
            else
            begin
                for (int i = 0; i < rcsfd_pkg::DATA_BYTES; i++)
                begin
                    if (q_entry.idx == 5'(i))
                    begin
                        data_next[i*8 +: 8] = q_entry.data;
                    end
                end
            end
        end
        if (step)
        begin
            out_valid_next              = 1'b1;
            out_data_next.pad           = '0;
            out_data_next.channel_index = ch_reg;
            out_data_next.channel_value = data_reg[rcsfd_pkg::CH_W-1:0];
            out_data_next.digital_one   = full_decode && flags_reg[rcsfd_pkg::FLAG_DIGITAL_ONE];
            out_data_next.digital_two   = full_decode && flags_reg[rcsfd_pkg::FLAG_DIGITAL_TWO];
            out_data_next.signal_status = status;
            out_last_next               = (ch_reg == last_ch);
            data_next                   = data_reg >> rcsfd_pkg::CH_W;
            ch_next                     = ch_reg + 4'd1;
            if (ch_reg == last_ch)
            begin
                emitting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        flags_reg    <= flags_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg  <= 1'b0;
            ch_reg        <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            emitting_reg  <= emitting_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // final result of a frame closes on channel 7 or 15
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
        (out_data_reg.channel_index == rcsfd_pkg::LAST_CH_ALL ||
         out_data_reg.channel_index == rcsfd_pkg::LAST_CH_HALF))
        else $error("last result on an unexpected channel");

    // a frame starts unpacking at channel 0
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(emitting_reg) |-> (ch_reg == 4'd0))
        else $error("frame unpack did not start at channel 0");

    // a pending non-final result means the frame is still unpacking
    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> emitting_reg)
        else $error("frame ended without a last result");

    // no queue command is taken while a frame is unpacking
    a_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (emitting_reg && !q_empty) |=> ($stable(data_reg) || $past(step)))
        else $error("frame store changed during unpack");

endmodule

### sv/rc_serial_frame_decoder.sv
// ---------------------------------------------------------------------------
// rc_serial_frame_decoder
// serial rc receiver frame decoder, 16 channels of 11 bits
// ---------------------------------------------------------------------------
// takes one received byte or line-gap event per transfer on the slave side;
// the front hunts for the 0x0f header, counts the 24 bytes after it and passes
// data and flag bytes and a good end byte (0x00) as commands through a queue of
// QUEUE_DEPTH entries, so the slave side takes one transfer per cycle while
// the queue has room. the back writes each popped command into the frame
// store; after a good end byte it unpacks the channels with an 11-bit
// shifter, one result per cycle while the master side is ready: 16 results
// with full_decode set, 8 with it clear. slave-side transfers stall while a
// frame is unpacking and the queue is full. a line gap or a bad end byte
// drops the frame with no result. full_decode resets to 1 (16 channels and
// the digital bits; 0 gives the first 8 channels) and is to be written only
// while the block is idle; the block itself does not enforce this
module rc_serial_frame_decoder #(
    parameter int QUEUE_DEPTH = rcsfd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        full_decode_we,
    input  logic        full_decode_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_index[3:0], channel_value[14:4], digital_one[15], digital_two[16],
    // signal_status[18:17], zero[23:19]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast    // last
);

    logic              full_decode_reg;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    rcsfd_pkg::qent_t  q_in;
    rcsfd_pkg::qent_t  q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_decode_reg <= 1'b1;
        end
        else if (full_decode_we)
        begin
            full_decode_reg <= full_decode_wdata;
        end
    end

    rcsfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in)
    );

    rcsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .full       (q_full),
        .empty      (q_empty)
    );

    rcsfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .full_decode   (full_decode_reg),
        .q_entry       (q_out),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
